// ===== rtl/core/rba_pkg.sv =====
// Shared types and constants for the row bitmap run allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rba_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_SLOTS = 64;
  localparam int ROW_W     = 5;
  localparam int SLOT_W    = 6;
  localparam int ADDR_W    = ROW_W + SLOT_W;

  // operation codes
  typedef enum logic [3:0] {
    OP_RESERVE    = 4'd0,
    OP_RESERVE_AT = 4'd1,
    OP_FIRST_FREE = 4'd2,
    OP_FIRST_FIT  = 4'd3,
    OP_CANCEL     = 4'd4,
    OP_CANCEL_OWN = 4'd5,
    OP_CANCEL_ALL = 4'd6,
    OP_QUERY      = 4'd7,
    OP_STATS      = 4'd8
  } op_t;

  // configuration register indexes
  localparam logic CFG_ROWS  = 1'b0;
  localparam logic CFG_SLOTS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_MATCH,
    ST_TAKE,
    ST_DONE
  } state_t;

  // one result transaction
  typedef struct packed {
    logic        ok;
    logic [4:0]  row_out;
    logic [5:0]  slot_out;
    logic [11:0] count_out;
    logic [11:0] free_total;
    logic [6:0]  longest_free_run;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/rba_owner_mem.sv =====
// Owner id store: one 16-bit tag per slot, one write and one registered read port.
// Depends on rba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rba_owner_mem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [rba_pkg::ADDR_W-1:0] waddr,
  input  wire logic [15:0]               wdata,
  input  wire logic [rba_pkg::ADDR_W-1:0] raddr,
  output logic      [15:0]               rdata
);
  import rba_pkg::*;

  logic [15:0] mem [MAX_ROWS*MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rba_seq.sv =====
// Sequencer and row bitmap: decodes each operation and walks the grid one slot a cycle, save for owner reads.
// Depends on rba_pkg and rba_owner_mem.
`timescale 1ns / 1ps
`default_nettype none
module rba_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [5:0]          nr,
  input  wire logic [6:0]          ns,
  input  wire logic                in_valid,
  input  wire logic [3:0]          in_operation,
  input  wire logic [4:0]          in_row,
  input  wire logic [5:0]          in_slot,
  input  wire logic [6:0]          in_run_length,
  input  wire logic [15:0]         in_owner_id,
  output logic                     busy,
  output logic                     res_valid,
  input  wire logic                res_ack,
  output rba_pkg::res_t            res
);
  import rba_pkg::*;

  state_t      st_r, st_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [5:0]  slot_r, slot_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [15:0] who_r, who_nxt;
  logic [4:0]  sr_r, sr_nxt;
  logic [5:0]  ss_r, ss_nxt;
  logic [6:0]  cur_r, cur_nxt;
  logic [6:0]  left_r, left_nxt;
  logic [4:0]  tr_r, tr_nxt;
  logic [5:0]  ts_r, ts_nxt;
  res_t        res_r, res_nxt;
  logic [MAX_SLOTS-1:0] bits_r [MAX_ROWS];

  // single-bit bitmap write port
  logic       bw_en, bw_val;
  logic [4:0] bw_row;
  logic [5:0] bw_slot;

  // owner store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_rdata;

  logic        in_grid, pos_bit, scan_bit, last_slot, last_row, run_ok;
  logic [63:0] run_mask, run_win;
  logic [7:0]  run_end;
  logic [6:0]  cur_inc, start_w;

  rba_owner_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (who_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    in_grid   = ({1'b0, row_r} < nr) && ({1'b0, slot_r} < ns);
    pos_bit   = bits_r[row_r][slot_r];
    scan_bit  = bits_r[sr_r][ss_r];
    last_slot = ({1'b0, ss_r} == (ns - 7'd1));
    last_row  = ({1'b0, sr_r} == (nr - 6'd1));
    run_mask  = (len_r == 7'd64) ? '1 : ((64'd1 << len_r[5:0]) - 64'd1);
    run_win   = bits_r[row_r] >> slot_r;
    run_end   = {2'b00, slot_r} + {1'b0, len_r};
    run_ok    = in_grid && (run_end <= {1'b0, ns}) && ((run_win & run_mask) == '0);
    cur_inc   = cur_r + 7'd1;
    start_w   = {1'b0, ss_r} - len_r + 7'd1;
  end

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    len_nxt  = len_r;
    who_nxt  = who_r;
    sr_nxt   = sr_r;
    ss_nxt   = ss_r;
    cur_nxt  = cur_r;
    left_nxt = left_r;
    tr_nxt   = tr_r;
    ts_nxt   = ts_r;
    res_nxt  = res_r;
    bw_en    = 1'b0;
    bw_val   = 1'b0;
    bw_row   = sr_r;
    bw_slot  = ss_r;
    mem_we    = 1'b0;
    mem_waddr = {tr_r, ts_r};
    mem_raddr = {sr_r, ss_r};
    res_valid = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          row_nxt  = in_row;
          slot_nxt = in_slot;
          len_nxt  = in_run_length;
          who_nxt  = in_owner_id;
          res_nxt  = '0;
          sr_nxt   = '0;
          ss_nxt   = '0;
          cur_nxt  = '0;
          st_nxt   = ST_EXEC;
        end
      end

      // positional work and scan set-up
      ST_EXEC: begin
        st_nxt = ST_DONE;
        case (op_r)
          OP_RESERVE: begin
            if (in_grid && !pos_bit) begin
              res_nxt.ok = 1'b1;
              tr_nxt     = row_r;
              ts_nxt     = slot_r;
              left_nxt   = 7'd1;
              st_nxt     = ST_TAKE;
            end
          end
          OP_RESERVE_AT: begin
            if (run_ok) begin
              res_nxt.ok = 1'b1;
              tr_nxt     = row_r;
              ts_nxt     = slot_r;
              left_nxt   = len_r;
              if (len_r != 7'd0) st_nxt = ST_TAKE;
            end
          end
          OP_FIRST_FREE: begin
            if (nr != 6'd0 && ns != 7'd0) st_nxt = ST_SCAN;
          end
          OP_FIRST_FIT: begin
            if (len_r == 7'd0) begin
              res_nxt.ok = 1'b1;
            end else if (len_r <= ns && nr != 6'd0) begin
              st_nxt = ST_SCAN;
            end
          end
          OP_CANCEL: begin
            if (in_grid && pos_bit) begin
              bw_en   = 1'b1;
              bw_row  = row_r;
              bw_slot = slot_r;
              res_nxt.ok        = 1'b1;
              res_nxt.count_out = 12'd1;
            end
          end
          OP_CANCEL_OWN, OP_CANCEL_ALL, OP_STATS: begin
            res_nxt.ok = 1'b1;
            if (nr != 6'd0 && ns != 7'd0) st_nxt = ST_SCAN;
          end
          OP_QUERY: res_nxt.ok = in_grid && !pos_bit;
          default: ;
        endcase
      end

      // one slot a cycle in row-major order, pausing in ST_MATCH for each owner read
      ST_SCAN: begin
        if (last_slot) begin
          ss_nxt  = '0;
          sr_nxt  = sr_r + 5'd1;
          cur_nxt = '0;
        end else begin
          ss_nxt = ss_r + 6'd1;
        end
        if (last_slot && last_row) st_nxt = ST_DONE;
        case (op_r)
          OP_FIRST_FREE: begin
            if (!scan_bit) begin
              res_nxt.ok       = 1'b1;
              res_nxt.row_out  = sr_r;
              res_nxt.slot_out = ss_r;
              tr_nxt   = sr_r;
              ts_nxt   = ss_r;
              left_nxt = 7'd1;
              st_nxt   = ST_TAKE;
            end
          end
          OP_FIRST_FIT: begin
            if (!scan_bit && cur_inc == len_r) begin
              res_nxt.ok       = 1'b1;
              res_nxt.row_out  = sr_r;
              res_nxt.slot_out = start_w[5:0];
              tr_nxt   = sr_r;
              ts_nxt   = start_w[5:0];
              left_nxt = len_r;
              st_nxt   = ST_TAKE;
            end else if (!last_slot) begin
              cur_nxt = scan_bit ? 7'd0 : cur_inc;
            end
          end
          OP_CANCEL_ALL: begin
            if (scan_bit) begin
              bw_en = 1'b1;
              res_nxt.count_out = res_r.count_out + 12'd1;
            end
          end
          OP_CANCEL_OWN: begin
            // owner read issued now, compared next cycle
            if (scan_bit) begin
              ss_nxt = ss_r;
              sr_nxt = sr_r;
              st_nxt = ST_MATCH;
            end
          end
          OP_STATS: begin
            if (scan_bit) begin
              res_nxt.count_out = res_r.count_out + 12'd1;
              if (!last_slot) cur_nxt = '0;
            end else begin
              res_nxt.free_total = res_r.free_total + 12'd1;
              if (!last_slot) cur_nxt = cur_inc;
              if (cur_inc > res_r.longest_free_run) res_nxt.longest_free_run = cur_inc;
            end
          end
          default: st_nxt = ST_DONE;
        endcase
      end

      ST_MATCH: begin
        if (mem_rdata == who_r) begin
          bw_en = 1'b1;
          res_nxt.count_out = res_r.count_out + 12'd1;
        end
        if (last_slot) begin
          ss_nxt = '0;
          sr_nxt = sr_r + 5'd1;
        end else begin
          ss_nxt = ss_r + 6'd1;
        end
        st_nxt = (last_slot && last_row) ? ST_DONE : ST_SCAN;
      end

      // mark slots and tag owners, one per cycle
      ST_TAKE: begin
        bw_en    = 1'b1;
        bw_val   = 1'b1;
        bw_row   = tr_r;
        bw_slot  = ts_r;
        mem_we   = 1'b1;
        ts_nxt   = ts_r + 6'd1;
        left_nxt = left_r - 7'd1;
        if (left_r == 7'd1) st_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ack) st_nxt = ST_IDLE;
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy = (st_r != ST_IDLE);
  assign res  = res_r;

  // control state and row bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int i = 0; i < MAX_ROWS; i++) bits_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (bw_en) bits_r[bw_row][bw_slot] <= bw_val;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    row_r  <= row_nxt;
    slot_r <= slot_nxt;
    len_r  <= len_nxt;
    who_r  <= who_nxt;
    sr_r   <= sr_nxt;
    ss_r   <= ss_nxt;
    cur_r  <= cur_nxt;
    left_r <= left_nxt;
    tr_r   <= tr_nxt;
    ts_r   <= ts_nxt;
    res_r  <= res_nxt;
  end

  a_take_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_TAKE |-> left_r != 7'd0)
    else $error("take with no slots left");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ack |=> res_valid && $stable(res_r))
    else $error("result dropped before taken");

  a_stats_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SCAN && op_r == OP_STATS |->
      ({1'b0, res_r.count_out} + {1'b0, res_r.free_total}) < 13'd2048)
    else $error("statistics overflow");

endmodule
`default_nettype wire

// ===== rtl/core/row_bitmap_run_allocator_core.sv =====
// Top level of the row bitmap run allocator: configuration registers and result register.
// Depends on rba_pkg and rba_seq.
//
// One transaction at a time. Positional operations (reserve, cancel, query) pass
// through the execute and done states; a reserve marks its slots in the take state.
// Searches and statistics walk the active grid one slot per cycle (a cancel-by-owner
// pauses at each reserved slot for the owner store read), then mark the slots reserved
// in the take state. The single-bit bitmap write port and the registered owner store
// read set this pace. in_stall is high while an operation is in progress; a finished
// result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`default_nettype none
module row_bitmap_run_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_operation,
  input  wire logic [4:0]  in_row,
  input  wire logic [5:0]  in_slot,
  input  wire logic [6:0]  in_run_length,
  input  wire logic [15:0] in_owner_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [4:0]       out_row_out,
  output logic [5:0]       out_slot_out,
  output logic [11:0]      out_count_out,
  output logic [11:0]      out_free_total,
  output logic [6:0]       out_longest_free_run
);
  import rba_pkg::*;

  logic [5:0] rows_r;
  logic [6:0] slots_r;
  logic [5:0] nr;
  logic [6:0] ns;
  logic       busy, res_valid, res_ack, out_valid_r;
  res_t       res, out_r;

  // clamp to the physical grid
  assign nr = (rows_r > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_r;
  assign ns = (slots_r > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS) : slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 6'd32;
      slots_r <= 7'd64;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROWS:  rows_r  <= cfg_wdata[5:0];
        CFG_SLOTS: slots_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rba_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .nr            (nr),
    .ns            (ns),
    .in_valid      (in_valid),
    .in_operation  (in_operation),
    .in_row        (in_row),
    .in_slot       (in_slot),
    .in_run_length (in_run_length),
    .in_owner_id   (in_owner_id),
    .busy          (busy),
    .res_valid     (res_valid),
    .res_ack       (res_ack),
    .res           (res)
  );

  assign in_stall = busy;

  // output register
  assign res_ack = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) out_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_ok               = out_r.ok;
  assign out_row_out          = out_r.row_out;
  assign out_slot_out         = out_r.slot_out;
  assign out_count_out        = out_r.count_out;
  assign out_free_total       = out_r.free_total;
  assign out_longest_free_run = out_r.longest_free_run;

endmodule
`default_nettype wire
